### sv/sss_pkg.sv
// Package for the sample set statistics block: widths, payload words and
// the request/response structs of the shared divider and of the square-root unit.
// No dependencies.
`default_nettype none

package sss_pkg;

  // Largest number of samples accumulated in one set.
  localparam int MAX_SAMPLES = 1024;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 8;
  localparam int OUT_CNT_W  = 11;
  localparam int LOG_MAX    = $clog2(MAX_SAMPLES);
  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W      = SAMPLE_W + LOG_MAX;
  localparam int SQR_W      = 2 * SAMPLE_W - 1;
  localparam int SQ_W       = SQR_W + LOG_MAX;
  localparam int MAG_W      = SUM_W;
  localparam int NUM_W      = (CNT_W + SQ_W > 2 * MAG_W) ? CNT_W + SQ_W : 2 * MAG_W;
  localparam int DEN_W      = 2 * CNT_W;
  localparam int VR_W       = 2 * SAMPLE_W - 1;
  localparam int VAR_W      = VR_W - FRAC_W;
  localparam int ROOT_W     = SAMPLE_W;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int STEP_W     = $clog2(MAG_W);
  localparam int DIV_IT_W   = $clog2(NUM_W);
  localparam int SQRT_IT_W  = $clog2(ROOT_W);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sss_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] mean;
    logic [VAR_W-1:0]           variance;
    logic [ROOT_W-1:0]          std_deviation;
    logic [OUT_CNT_W-1:0]       sample_count;
    logic                       overflow;
  } sss_out_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } sss_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } sss_div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sss_sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sss_sqrt_rsp_t;

endpackage

`default_nettype wire

### sv/sss_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sss_pkg for its widths and request/response structs.
`default_nettype none

module sss_div
  import sss_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sss_div_req_t req,
  output sss_div_rsp_t      rsp
);

  logic                busy;
  logic                done;
  logic [DIV_IT_W-1:0] iter;
  logic [NUM_W-1:0]    dvd;
  logic [DEN_W-1:0]    rem;
  logic [DEN_W-1:0]    dsr;
  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_sub;
  logic                fits;

  // Bring down the next dividend bit and try the subtraction.
  assign rem_sh  = {rem, dvd[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && iter == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dsr  <= req.divisor;
      rem  <= '0;
      iter <= DIV_IT_W'(NUM_W - 1);
    end else if (busy) begin
      dvd  <= {dvd[NUM_W-2:0], fits};
      rem  <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      iter <= iter - 1'b1;
    end
  end

  // The quotient has been shifted into the dividend register.
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

`default_nettype wire

### sv/sss_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on sss_pkg for its widths and request/response structs.
`default_nettype none

module sss_sqrt
  import sss_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sss_sqrt_req_t req,
  output sss_sqrt_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [SQRT_IT_W-1:0] iter;
  logic [RAD_W-1:0]     rad;
  logic [ROOT_W-1:0]    root;
  logic [ROOT_W+1:0]    rem;
  logic [ROOT_W+1:0]    rem_sh;
  logic [ROOT_W+1:0]    trial;
  logic                 fits;

  // The top two bits of the partial remainder are zero until the last step.
  assign rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && iter == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      root <= '0;
      rem  <= '0;
      iter <= SQRT_IT_W'(ROOT_W - 1);
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
      iter <= iter - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

`default_nettype wire

### sv/sample_set_statistics.sv
// Top level of the sample set statistics block: accumulators, the finishing
// sequencer with its shared shift-add unit, and the result register.
// Depends on sss_pkg, sss_div and sss_sqrt.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-----------------------------
//   smp     | in        | smp_valid/smp_stall | sss_in_t  (sample, last)
//   res     | out       | res_valid/res_stall | sss_out_t (statistics)
//
// Samples are taken one per cycle while a set is being accumulated.
// After the word flagged last, the block stalls its input until the result
// register takes the statistics word. It first drains the squaring pipeline,
// then runs the shift-add multiplies, two passes through the bit-serial
// divider and the bit-serial square root.
// Reset is synchronous and active high; it empties the set and the result
// register. A result waiting on res_stall does not block the next set's
// samples; only a second finished set waits for the result register.
`default_nettype none

module sample_set_statistics
  import sss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    smp_valid,
  output logic         smp_stall,
  input  wire sss_in_t smp_word,
  output logic         res_valid,
  input  wire logic    res_stall,
  output sss_out_t     res_word
);

  typedef enum logic [11:0] {
    S_ACCUM  = 12'b0000_0000_0001,
    S_DRAIN  = 12'b0000_0000_0010,
    S_MULN   = 12'b0000_0000_0100,
    S_MULS   = 12'b0000_0000_1000,
    S_SUB    = 12'b0000_0001_0000,
    S_VSTART = 12'b0000_0010_0000,
    S_VWAIT  = 12'b0000_0100_0000,
    S_RSTART = 12'b0000_1000_0000,
    S_RWAIT  = 12'b0001_0000_0000,
    S_MSTART = 12'b0010_0000_0000,
    S_MWAIT  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Set accumulators.
  logic [CNT_W-1:0]           cnt;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [SUM_W-1:0]    run_sum;
  logic [SQ_W-1:0]            run_sumsq;
  logic                       dropped;

  // Squaring pipeline feeding the sum of squares.
  logic                         p1;
  logic                         p2;
  logic signed [SAMPLE_W-1:0]   xq;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [SQR_W-1:0]             sq;

  // Finishing datapath.
  logic [MAG_W-1:0]  mag;
  logic              sum_neg;
  logic [MAG_W-1:0]  mplr;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  acc;
  logic [NUM_W-1:0]  prod;
  logic [DEN_W-1:0]  den;
  logic [VR_W-1:0]   var_raw;
  logic [ROOT_W-1:0] std_dev;
  logic signed [SAMPLE_W-1:0] mean;

  logic [NUM_W-1:0] opa;
  logic [NUM_W-1:0] opb;
  logic             op_sub;
  logic [NUM_W-1:0] add_res;

  logic smp_fire;
  logic room;
  logic res_load;
  logic [SAMPLE_W-1:0] quo_lo;

  sss_div_req_t  div_req;
  sss_div_rsp_t  div_rsp;
  sss_sqrt_req_t sqrt_req;
  sss_sqrt_rsp_t sqrt_rsp;

  sss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sss_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  assign smp_stall = (state != S_ACCUM);
  assign smp_fire  = smp_valid && !smp_stall;
  assign room      = cnt < CNT_W'(MAX_SAMPLES);
  assign res_load  = (state == S_DONE) && (!res_valid || !res_stall);
  assign sq_full   = xq * xq;
  assign quo_lo    = div_rsp.quotient[SAMPLE_W-1:0];

  // One shared adder serves both shift-add multiplies and the final
  // subtraction N*sumsq - sum^2.
  always_comb begin
    opa    = '0;
    opb    = '0;
    op_sub = 1'b0;
    unique case (state)
      S_MULN: begin
        opa = acc << 1;
        opb = mplr[MAG_W-1] ? NUM_W'(run_sumsq) : '0;
      end
      S_MULS: begin
        opa = prod << 1;
        opb = mplr[MAG_W-1] ? NUM_W'(mag) : '0;
      end
      S_SUB: begin
        opa    = acc;
        opb    = prod;
        op_sub = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign add_res = opa + (op_sub ? ~opb : opb) + NUM_W'(op_sub);

  always_comb begin
    state_next = state;
    div_req    = '0;
    sqrt_req   = '0;
    unique case (state)
      S_ACCUM: begin
        if (smp_fire && smp_word.last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!p1 && !p2) state_next = S_MULN;
      end
      S_MULN: begin
        if (step == STEP_W'(CNT_W - 1)) state_next = S_MULS;
      end
      S_MULS: begin
        if (step == STEP_W'(MAG_W - 1)) state_next = S_SUB;
      end
      S_SUB: begin
        state_next = S_VSTART;
      end
      S_VSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc;
        div_req.divisor  = den;
        state_next       = S_VWAIT;
      end
      S_VWAIT: begin
        if (div_rsp.done) state_next = S_RSTART;
      end
      S_RSTART: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = RAD_W'(var_raw);
        state_next        = S_RWAIT;
      end
      S_RWAIT: begin
        if (sqrt_rsp.done) state_next = S_MSTART;
      end
      S_MSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = NUM_W'(mag);
        div_req.divisor  = DEN_W'(cnt);
        state_next       = S_MWAIT;
      end
      S_MWAIT: begin
        if (div_rsp.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (res_load) state_next = S_ACCUM;
      end
      default: begin
        state_next = S_ACCUM;
      end
    endcase
  end

  // Control and set state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCUM;
      p1        <= 1'b0;
      p2        <= 1'b0;
      res_valid <= 1'b0;
      cnt       <= '0;
      run_min   <= SAMPLE_W'(2**(SAMPLE_W-1) - 1);
      run_max   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      run_sum   <= '0;
      run_sumsq <= '0;
      dropped   <= 1'b0;
    end else begin
      state <= state_next;
      p1    <= smp_fire && room;
      p2    <= p1;
      if (p2) run_sumsq <= run_sumsq + SQ_W'(sq);
      if (smp_fire) begin
        if (room) begin
          cnt     <= cnt + 1'b1;
          run_sum <= run_sum + {{(SUM_W-SAMPLE_W){smp_word.sample[SAMPLE_W-1]}},
                                smp_word.sample};
          if (smp_word.sample < run_min) run_min <= smp_word.sample;
          if (smp_word.sample > run_max) run_max <= smp_word.sample;
        end else begin
          // A full set drops the word but still honors its last flag.
          dropped <= 1'b1;
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
        cnt       <= '0;
        run_min   <= SAMPLE_W'(2**(SAMPLE_W-1) - 1);
        run_max   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        run_sum   <= '0;
        run_sumsq <= '0;
        dropped   <= 1'b0;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (smp_fire) xq <= smp_word.sample;
    sq <= sq_full[SQR_W-1:0];

    unique case (state)
      S_DRAIN: begin
        // Multiply N by the sum of squares, MSB of N first.
        mag     <= run_sum[SUM_W-1] ? MAG_W'(-run_sum) : MAG_W'(run_sum);
        sum_neg <= run_sum[SUM_W-1];
        mplr    <= MAG_W'(cnt) << (MAG_W - CNT_W);
        acc     <= '0;
        step    <= '0;
      end
      S_MULN: begin
        acc <= add_res;
        if (step == STEP_W'(CNT_W - 1)) begin
          mplr <= mag;
          prod <= '0;
          step <= '0;
        end else begin
          mplr <= mplr << 1;
          step <= step + 1'b1;
        end
      end
      S_MULS: begin
        prod <= add_res;
        mplr <= mplr << 1;
        step <= step + 1'b1;
      end
      S_SUB: begin
        acc <= add_res;
        den <= DEN_W'(cnt) * DEN_W'(cnt);
      end
      S_VWAIT: begin
        if (div_rsp.done) var_raw <= div_rsp.quotient[VR_W-1:0];
      end
      S_RWAIT: begin
        if (sqrt_rsp.done) std_dev <= sqrt_rsp.root;
      end
      S_MWAIT: begin
        // The mean truncates toward zero: divide the magnitude, then negate.
        if (div_rsp.done) mean <= sum_neg ? -quo_lo : quo_lo;
      end
      default: begin
      end
    endcase

    if (res_load) begin
      res_word.minimum       <= run_min;
      res_word.maximum       <= run_max;
      res_word.mean          <= mean;
      res_word.variance      <= var_raw[VR_W-1:FRAC_W];
      res_word.std_deviation <= std_dev;
      res_word.sample_count  <= OUT_CNT_W'(cnt);
      res_word.overflow      <= dropped;
    end
  end

  // The squaring pipeline must be empty before the multiply reads sumsq.
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULN) |-> (!p1 && !p2))
    else $error("sum of squares read while the squaring pipeline is busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond the set limit");

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside the finishing state");

  a_res_order: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (res_word.minimum <= res_word.maximum) && (cnt == '0))
    else $error("loaded result has min above max or set not cleared");

endmodule

`default_nettype wire

### dv/sample_set_statistics_tb.sv
// Self-checking testbench for sample_set_statistics: streams sets of Q8.8 samples
// with random idling on both channels and checks every statistics word it returns.
// Depends on sss_pkg and the sample_set_statistics RTL.
`timescale 1ns / 1ps

module sample_set_statistics_tb;
  import sss_pkg::*;

  // The run gives up after this many cycles. The slowest correct run is far below it.
  localparam int LIMIT_CYCLES    = 800000;
  // Idle cycles after the last expected word, to catch stray results.
  localparam int DRAIN_CYCLES    = 400;
  localparam int RANDOM_ITEMS    = 1150;
  localparam int MIN_RANDOM_SETS = 12;
  // The set-full case goes in after this many random sets. The sender holds off
  // until the block is idle after this many.
  localparam int FULL_SET_AT     = 4;
  localparam int HOLD_OFF_AT     = 8;

  // These are the kinds of sample sets that the random part draws.
  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_CORNERS, SPREAD_FLAT} spread_e;

  logic     clk;
  logic     rst       = 1'b1;
  logic     smp_valid = 1'b0;
  sss_in_t  smp_word  = '0;
  logic     res_stall = 1'b0;
  logic     smp_stall;
  logic     res_valid;
  sss_out_t res_word;

  sample_set_statistics dut (
    .clk      (clk),
    .rst      (rst),
    .smp_valid(smp_valid),
    .smp_stall(smp_stall),
    .smp_word (smp_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word (res_word)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // These are the sample words that wait for the driver, and the statistics
  // words that the block still owes, oldest first.
  sss_in_t  pending[$];
  sss_out_t stats_due[$];

  int words_pushed = 0;
  int words_taken  = 0;
  int errors       = 0;
  int cycles       = 0;
  // The monitor sets this at each rising edge. The driver reads it at the
  // following falling edge to learn whether its word went through.
  logic smp_took   = 1'b0;

  // The driver and the receiver each keep an idle countdown. They also keep a
  // count of the words (driver) or cycles (receiver) left in a calm stretch, during which they never idle.
  int tx_gap = 0, tx_calm = 0;
  int rx_left = 0, rx_calm = 0;

  int corner_vals[6] = '{-32768, -32767, -1, 0, 1, 32767};

  // This is the predicted state of the set being accumulated. It mirrors the
  // block's accumulators, held in wide signed integers so that no sum wraps.
  int     set_count;
  longint set_min, set_max, set_sum, set_sumsq;
  logic   set_dropped;

  function automatic void open_set();
    set_count   = 0;
    set_min     = 32767;
    set_max     = -32768;
    set_sum     = 0;
    set_sumsq   = 0;
    set_dropped = 1'b0;
  endfunction

  // Floor of the square root, found one bit at a time from the top. The
  // radicand here stays below 2^31, so 25 bits of root are plenty.
  function automatic longint floor_root(longint v);
    longint r, trial;
    r = 0;
    for (int i = 24; i >= 0; i--) begin
      trial = r | (longint'(1) << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Close the current set and work out its statistics word. The variance is
  // (N*sumsq - sum^2) / N^2, which is exact in 64 bits: the numerator stays
  // below 2^51 with 1024 samples. The mean relies on signed division, which
  // truncates toward zero as the block's mean must.
  function automatic sss_out_t close_set();
    sss_out_t r;
    longint n, mag, num, den;
    n   = set_count;
    mag = (set_sum < 0) ? -set_sum : set_sum;
    num = n * set_sumsq - mag * mag;
    den = n * n;
    r.minimum       = SAMPLE_W'(set_min);
    r.maximum       = SAMPLE_W'(set_max);
    r.mean          = SAMPLE_W'(set_sum / n);
    r.variance      = VAR_W'(num / (den * 256));
    r.std_deviation = ROOT_W'(floor_root(num / den));
    r.sample_count  = OUT_CNT_W'(n);
    r.overflow      = set_dropped;
    return r;
  endfunction

  // Fold one accepted sample word into the predicted set. Once the set is
  // full, samples are dropped and only mark overflow. A dropped word flagged
  // last still closes the set.
  task automatic absorb_sample(sss_in_t w);
    longint x;
    x = $signed(w.sample);
    if (set_count < MAX_SAMPLES) begin
      set_count++;
      if (x < set_min) set_min = x;
      if (x > set_max) set_max = x;
      set_sum   += x;
      set_sumsq += x * x;
    end else begin
      set_dropped = 1'b1;
    end
    if (w.last) begin
      stats_due.push_back(close_set());
      open_set();
    end
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_stats(sss_out_t got);
    sss_out_t want;
    if (stats_due.size() == 0) begin
      $display("%0t: statistics word with none expected, actual min %0d max %0d count %0d",
               $time, got.minimum, got.maximum, got.sample_count);
      errors++;
    end else begin
      want = stats_due.pop_front();
      check_field("minimum", want.minimum, got.minimum);
      check_field("maximum", want.maximum, got.maximum);
      check_field("mean", want.mean, got.mean);
      check_field("variance", want.variance, got.variance);
      check_field("std_deviation", want.std_deviation, got.std_deviation);
      check_field("sample_count", want.sample_count, got.sample_count);
      check_field("overflow", want.overflow, got.overflow);
    end
  endtask

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic push_word(int value, bit fin);
    sss_in_t w;
    w.sample = SAMPLE_W'(value);
    w.last   = fin;
    pending.push_back(w);
    words_pushed++;
  endtask

  // Hold the sender back until every pushed word has been taken and every
  // expected statistics word has come back. The checks run at the falling
  // edge, where neither count can move, and the task returns on a rising edge
  // so that new words are queued away from the driver's edge.
  task automatic wait_idle();
    while (words_taken != words_pushed || stats_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // The monitor samples both channels at the rising edge. An accepted result is
  // checked before the sample of the same edge is folded in, although the
  // finishing latency keeps the two from belonging to the same set.
  always @(posedge clk) begin
    smp_took = 1'b0;
    if (!rst) begin
      if (res_valid && !res_stall) check_stats(res_word);
      if (smp_valid && !smp_stall) begin
        smp_took = 1'b1;
        words_taken++;
        absorb_sample(smp_word);
      end
    end
  end

  // The driver moves on at the falling edge. A word is held unchanged until it
  // is taken. Back-to-back words keep valid high through a single assignment.
  always @(negedge clk) begin : feed
    sss_in_t nxt_word;
    logic    nxt_valid;
    nxt_word  = smp_word;
    nxt_valid = smp_valid;
    if (!rst && (!smp_valid || smp_took)) begin
      nxt_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending.size() != 0) begin
        nxt_word  = pending.pop_front();
        nxt_valid = 1'b1;
        if (tx_calm > 0) begin
          tx_calm--;
        end else begin
          tx_gap = pick_gap();
          if ($urandom_range(0, 149) == 0) tx_calm = $urandom_range(40, 250);
        end
      end
    end
    smp_valid <= nxt_valid;
    smp_word  <= nxt_word;
  end

  // The receiver stalls in random stretches, with free cycles between them.
  // Stalls do not depend on res_valid, so they land anywhere in the
  // finishing sequence and on the result itself.
  always @(negedge clk) begin
    if (!rst) begin
      if (rx_left > 0) begin
        res_stall <= 1'b1;
        rx_left--;
      end else begin
        res_stall <= 1'b0;
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_left = pick_gap();
          if ($urandom_range(0, 299) == 0) rx_calm = $urandom_range(100, 600);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("sample_set_statistics_tb: errors");
      $finish;
    end
  end

  initial begin
    spread_e flavor;
    int      len, center, value, pick, rand_items, rand_sets;
    rand_items = 0;
    rand_sets  = 0;
    open_set();
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // These are directed sets. Single samples hold 0, both extremes of the range and -1.
    push_word(0, 1'b1);
    push_word(32767, 1'b1);
    push_word(-32768, 1'b1);
    push_word(-1, 1'b1);
    // The two extremes together give the largest variance and deviation, in both orders.
    push_word(-32768, 1'b0);
    push_word(32767, 1'b1);
    push_word(32767, 1'b0);
    push_word(-32768, 1'b1);
    // Flat sets at either end have zero variance and an extreme mean.
    push_word(-32768, 1'b0);
    push_word(-32768, 1'b0);
    push_word(-32768, 1'b1);
    push_word(32767, 1'b0);
    push_word(32767, 1'b1);
    // An odd sum truncates toward zero on both sides: -3/2 gives -1 and 3/2 gives 1.
    push_word(-3, 1'b0);
    push_word(0, 1'b1);
    push_word(3, 1'b0);
    push_word(0, 1'b1);
    // Alternating bit patterns toggle every sample bit.
    push_word(16'h5555, 1'b0);
    push_word(16'haaaa, 1'b1);

    // The sender pauses here until the block has returned everything.
    wait_idle();

    // Random sets follow. They are mostly short, so that many statistics words come back.
    while (rand_items < RANDOM_ITEMS || rand_sets < MIN_RANDOM_SETS) begin
      if (rand_sets == FULL_SET_AT) begin
        // Set full: a whole set of random samples, then two samples past the
        // limit. Last is flagged on a third one that is also dropped, yet
        // still closes the set with overflow raised.
        for (int i = 0; i < MAX_SAMPLES; i++) push_word($urandom_range(0, 65535), 1'b0);
        push_word($urandom_range(0, 65535), 1'b0);
        push_word($urandom_range(0, 65535), 1'b0);
        push_word($urandom_range(0, 65535), 1'b1);
        rand_items += MAX_SAMPLES + 3;
      end
      if (rand_sets == HOLD_OFF_AT) wait_idle();

      flavor = spread_e'($urandom_range(0, 3));
      pick   = $urandom_range(0, 9);
      if (pick < 6)      len = $urandom_range(1, 4);
      else if (pick < 9) len = $urandom_range(5, 16);
      else               len = $urandom_range(17, 60);
      center = $urandom_range(0, 65535);

      for (int i = 0; i < len; i++) begin
        case (flavor)
          SPREAD_FULL:    value = $urandom_range(0, 65535);
          SPREAD_NARROW:  value = center + int'($urandom_range(0, 64)) - 32;
          SPREAD_CORNERS: value = corner_vals[$urandom_range(0, 5)];
          default:        value = center;
        endcase
        push_word(value, i == len - 1);
      end
      rand_items += len;
      rand_sets++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("sample_set_statistics_tb: clean");
    end else begin
      $display("sample_set_statistics_tb: errors");
    end
    $finish;
  end

endmodule
